>>> hdl/dfrc_pkg.sv
`timescale 1ns / 1ps

package dfrc_pkg;

   localparam int ROUNDS   = 16;
   localparam int KEY_W    = 48;
   localparam int HALF_W   = 32;
   localparam int ROUND_W  = $clog2(ROUNDS);

   localparam logic FUNC_KEY_WRITE = 1'b0;
   localparam logic FUNC_BLOCK     = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam logic [5:0] E_TAB [KEY_W] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
      6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
      6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
      6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
      6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] P_TAB [HALF_W] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   // rows of each box laid out one after another, index is row * 16 + col
   localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
   };

   function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] r,
                                                 input logic [KEY_W-1:0]  k);
      logic [KEY_W-1:0]  e;
      logic [KEY_W-1:0]  x;
      logic [HALF_W-1:0] s;
      logic [HALF_W-1:0] p;
      logic [5:0]        six;
      e = '0;
      s = '0;
      p = '0;
      for (int j = 0; j < KEY_W; j++) begin
         e[KEY_W-1-j] = r[5'(HALF_W - int'(E_TAB[j]))];
      end
      x = e ^ k;
      for (int g = 0; g < 8; g++) begin
         six = x[KEY_W-1-6*g -: 6];
         s[HALF_W-1-4*g -: 4] = SBOX_TAB[g][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < HALF_W; i++) begin
         p[HALF_W-1-i] = s[5'(HALF_W - int'(P_TAB[i]))];
      end
      return p;
   endfunction

endpackage

>>> hdl/des_feistel_round_core_unit.sv
`timescale 1ns / 1ps
// block word: 16 rounds, one round of the shared f unit per cycle, the last one held while
// a result waits; result registered on the last round; next word taken in the cycle after
// key write word: taken while idle, no result
// the result register lets a new word in while a result waits
// synchronous active-high reset clears control; round keys are undefined until written
module des_feistel_round_core_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [3:0]                    req_key_index,
   input  logic [dfrc_pkg::KEY_W-1:0]    req_round_key,
   input  logic [dfrc_pkg::HALF_W-1:0]   req_left_in,
   input  logic [dfrc_pkg::HALF_W-1:0]   req_right_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dfrc_pkg::HALF_W-1:0]   rsp_left_out,
   output logic [dfrc_pkg::HALF_W-1:0]   rsp_right_out
);
   import dfrc_pkg::*;

   state_type            state_ff, state_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [HALF_W-1:0]    left_ff, left_in;
   logic [HALF_W-1:0]    right_ff, right_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HALF_W-1:0]    rsp_left_ff, rsp_left_in;
   logic [HALF_W-1:0]    rsp_right_ff, rsp_right_in;
   logic [KEY_W-1:0]     key_ff [ROUNDS];

   logic                 req_take;
   logic                 key_wr;
   logic                 blk_start;
   logic                 last_round;
   logic                 out_free;
   logic                 finish;
   logic                 step;
   logic [HALF_W-1:0]    f_out;

   assign req_take   = req_valid && !req_stall;
   assign key_wr     = req_take && (req_func == FUNC_KEY_WRITE);
   assign blk_start  = req_take && (req_func == FUNC_BLOCK);
   assign last_round = (round_ff == ROUND_W'(ROUNDS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step       = (state_ff == ST_RUN) && (!last_round || out_free);
   assign finish     = step && last_round;

   // shared round unit
   assign f_out = round_f(right_ff, key_ff[round_ff]) ^ left_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (blk_start) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      round_in     = round_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      case (state_ff)
         ST_IDLE: begin
            if (blk_start) begin
               round_in = '0;
               left_in  = req_left_in;
               right_in = req_right_in;
            end
         end
         ST_RUN: begin
            if (step) begin
               round_in = round_ff + 1'b1;
               left_in  = right_ff;
               right_in = f_out;
            end
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = f_out;
               rsp_right_in = right_ff;
            end
         end
         default: begin
            round_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      if (key_wr) begin
         key_ff[req_key_index] <= req_round_key;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

>>> dv/tb_des_feistel_round_core_unit.sv
`timescale 1ns / 1ps

module tb_des_feistel_round_core_unit;
   import dfrc_pkg::*;

   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_WORDS  = 650;

   typedef logic [15:0][KEY_W-1:0] key_set_type;

   typedef struct packed {
      logic              func;
      logic [3:0]        idx;
      logic [KEY_W-1:0]  key;
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
   } req_word_type;

   typedef struct packed {
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
   } half_pair_type;

   localparam int EXP_SEL [48] = '{
      32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11,
      12, 13, 12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21,
      22, 23, 24, 25, 24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
   };

   localparam int PERM_SEL [32] = '{
      16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
      2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
   };

   localparam int SBOX_VAL [8][4][16] = '{
      '{'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7},
        '{0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8},
        '{4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0},
        '{15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13}},
      '{'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10},
        '{3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5},
        '{0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15},
        '{13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9}},
      '{'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8},
        '{13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1},
        '{13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7},
        '{1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12}},
      '{'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15},
        '{13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9},
        '{10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4},
        '{3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14}},
      '{'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9},
        '{14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6},
        '{4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14},
        '{11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3}},
      '{'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11},
        '{10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8},
        '{9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6},
        '{4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13}},
      '{'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1},
        '{13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6},
        '{1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2},
        '{6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12}},
      '{'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7},
        '{1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2},
        '{7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8},
        '{2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_func = 1'b0;
   logic [3:0]        req_key_index = '0;
   logic [KEY_W-1:0]  req_round_key = '0;
   logic [HALF_W-1:0] req_left_in = '0;
   logic [HALF_W-1:0] req_right_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [HALF_W-1:0] rsp_left_out;
   logic [HALF_W-1:0] rsp_right_out;

   req_word_type  pend_words [$];
   half_pair_type cipher_q [$];
   key_set_type   plan_keys;
   key_set_type   mirror_keys;
   req_word_type  next_word;
   half_pair_type got_pair;
   int         words_total = 0;
   int         words_taken = 0;
   int         blocks_sent = 0;
   int         results_got = 0;
   int         n_blocks = 0;
   int         n_key_writes = 0;
   int         n_trips = 0;
   int         errors = 0;
   int         gap_left = 0;
   int         hold_left = 0;
   int         cycle_cnt = 0;
   bit         drv_burst = 1'b0;
   bit         mon_burst = 1'b0;

   des_feistel_round_core_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_key_index (req_key_index),
      .req_round_key (req_round_key),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [HALF_W-1:0] f_mix(input logic [HALF_W-1:0] r,
                                               input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0]  x;
      logic [HALF_W-1:0] s;
      logic [HALF_W-1:0] p;
      logic [5:0]        six;
      int                row;
      int                col;
      x = '0;
      s = '0;
      p = '0;
      for (int j = 0; j < 48; j++) begin
         x[47-j] = r[32-EXP_SEL[j]];
      end
      x = x ^ k;
      for (int g = 0; g < 8; g++) begin
         six = x[47-6*g -: 6];
         row = {six[5], six[0]};
         col = six[4:1];
         s[31-4*g -: 4] = 4'(SBOX_VAL[g][row][col]);
      end
      for (int i = 0; i < 32; i++) begin
         p[31-i] = s[32-PERM_SEL[i]];
      end
      return p;
   endfunction

   function automatic half_pair_type feistel16(input logic [HALF_W-1:0] li,
                                               input logic [HALF_W-1:0] ri,
                                               input key_set_type ks);
      logic [HALF_W-1:0] l;
      logic [HALF_W-1:0] r;
      logic [HALF_W-1:0] t;
      half_pair_type     res;
      l = li;
      r = ri;
      for (int i = 0; i < 16; i++) begin
         t = r;
         r = f_mix(r, ks[i]) ^ l;
         l = t;
      end
      res.left = r;
      res.right = l;
      return res;
   endfunction

   function automatic logic [HALF_W-1:0] rand_half();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return KEY_W'({$urandom(), $urandom()});
      endcase
   endfunction

   task automatic push_key(input logic [3:0] idx, input logic [KEY_W-1:0] key);
      req_word_type w;
      w.func = FUNC_KEY_WRITE;
      w.idx = idx;
      w.key = key;
      w.left = $urandom();
      w.right = $urandom();
      plan_keys[idx] = key;
      pend_words.push_back(w);
      n_key_writes++;
   endtask

   task automatic push_block(input logic [HALF_W-1:0] l, input logic [HALF_W-1:0] r);
      req_word_type w;
      w.func = FUNC_BLOCK;
      w.idx = 4'($urandom());
      w.key = KEY_W'({$urandom(), $urandom()});
      w.left = l;
      w.right = r;
      pend_words.push_back(w);
      n_blocks++;
   endtask

   // driver: key writes wait until no block word is in flight
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            if (req_func == FUNC_KEY_WRITE) begin
               mirror_keys[req_key_index] = req_round_key;
            end else begin
               cipher_q.push_back(feistel16(req_left_in, req_right_in, mirror_keys));
               blocks_sent++;
            end
            words_taken++;
            gap_left = drv_burst ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pend_words.size() != 0 &&
                      (pend_words[0].func == FUNC_BLOCK || blocks_sent == results_got)) begin
            next_word = pend_words.pop_front();
            req_valid <= 1'b1;
            req_func <= next_word.func;
            req_key_index <= next_word.idx;
            req_round_key <= next_word.key;
            req_left_in <= next_word.left;
            req_right_in <= next_word.right;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word left_out %h right_out %h",
                        $time, rsp_left_out, rsp_right_out);
            end else begin
               got_pair = cipher_q.pop_front();
               if (rsp_left_out !== got_pair.left) begin
                  errors++;
                  $display("%0t: left_out expected %h actual %h",
                           $time, got_pair.left, rsp_left_out);
               end
               if (rsp_right_out !== got_pair.right) begin
                  errors++;
                  $display("%0t: right_out expected %h actual %h",
                           $time, got_pair.right, rsp_right_out);
               end
            end
            results_got <= results_got + 1;
            hold_left = mon_burst ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) mon_burst = !mon_burst;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("des_feistel_round_core_unit: mismatch");
         $finish;
      end
   end

   initial begin : stim
      int            n_rand;
      int            pick;
      key_set_type   ks;
      logic [HALF_W-1:0] pl;
      logic [HALF_W-1:0] pr;
      half_pair_type ct;
      n_rand = 0;
      plan_keys = '0;
      mirror_keys = '0;

      // full key set, slot index stepping by 7, extremes written first
      for (int i = 0; i < 16; i++) begin
         case (i)
            0: push_key(4'(i * 7), '0);
            1: push_key(4'(i * 7), '1);
            2: push_key(4'(i * 7), 48'h8000_0000_0000);
            3: push_key(4'(i * 7), 48'h0000_0000_0001);
            default: push_key(4'(i * 7), KEY_W'({$urandom(), $urandom()}));
         endcase
      end
      push_block('0, '0);
      push_block('1, '1);
      push_block('0, '1);
      push_block('1, '0);
      push_block(32'h8000_0000, 32'h0000_0001);
      push_block($urandom(), $urandom());
      push_key(4'd0, '1);
      push_key(4'd15, '0);
      push_block($urandom(), $urandom());

      while (n_rand < RAND_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            push_block(rand_half(), rand_half());
            n_rand++;
         end else if (pick < 94) begin
            push_key(4'($urandom()), rand_key());
            n_rand++;
         end else begin
            // encrypt, reload the keys reversed, decrypt the cipher word
            ks = plan_keys;
            pl = rand_half();
            pr = rand_half();
            ct = feistel16(pl, pr, ks);
            push_block(pl, pr);
            for (int i = 0; i < 16; i++) push_key(4'(i), ks[15-i]);
            push_block(ct.left, ct.right);
            n_trips++;
            n_rand += 18;
         end
      end
      words_total = pend_words.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (words_taken != words_total || blocks_sent != results_got ||
             cipher_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d data blocks, %0d round key writes",
               words_total, n_blocks, n_key_writes);
      $display("including %0d encrypt/decrypt round trips with reversed keys, %0d errors",
               n_trips, errors);
      if (errors == 0 && cipher_q.size() == 0) begin
         $display("des_feistel_round_core_unit: match");
      end else begin
         $display("des_feistel_round_core_unit: mismatch");
      end
      $finish;
   end

endmodule
